/* rtl/core/spq_pkg.sv */
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEF         = 16;
   localparam int PRIORITY_BITS_DEF = 16;
   localparam int VALUE_BITS_DEF    = 32;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MOVE,
      ST_PLACE,
      ST_DONE
   } spq_state_type;

   typedef struct packed {
      logic       is_empty;
      logic       is_full;
      status_type status;
   } res_flags_type;

endpackage

`default_nettype wire

/* rtl/core/spq_mem.sv */
`default_nettype none

module spq_mem
   import spq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int DATA_BITS = PRIORITY_BITS_DEF + VALUE_BITS_DEF,
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [DATA_BITS-1:0] rd_data_ff
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/core/spq_ctrl.sv */
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW           = $clog2(DEPTH + 1),
   localparam int DW           = PRIORITY_BITS + VALUE_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire mode_type                 req_mode,
   input  wire logic [PRIORITY_BITS-1:0] req_priority,
   input  wire logic [VALUE_BITS-1:0]    req_value,
   output logic                          res_valid,
   input  wire logic                     res_ready,
   output logic [VALUE_BITS-1:0]         res_removed_value,
   output logic [PRIORITY_BITS-1:0]      res_head_priority,
   output logic [VALUE_BITS-1:0]         res_head_value,
   output res_flags_type                 res_flags,
   output logic                          mem_wr_en,
   output logic [AW-1:0]                 mem_wr_addr,
   output logic [DW-1:0]                 mem_wr_data,
   output logic [AW-1:0]                 mem_rd_addr,
   input  wire logic [DW-1:0]            mem_rd_data
);

   spq_state_type              state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              idx_ff, idx_in;
   mode_type                   op_ff, op_in;
   status_type                 status_ff, status_in;
   logic [PRIORITY_BITS-1:0]   new_pri_ff, new_pri_in;
   logic [VALUE_BITS-1:0]      new_val_ff, new_val_in;
   logic [PRIORITY_BITS-1:0]   head_pri_ff, head_pri_in;
   logic [VALUE_BITS-1:0]      head_val_ff, head_val_in;
   logic [VALUE_BITS-1:0]      removed_ff, removed_in;

   logic                       accept;
   logic [CW-1:0]              idx_dec;
   logic [PRIORITY_BITS-1:0]   rd_pri;
   logic [VALUE_BITS-1:0]      rd_val;
   logic                       stays_ahead;

   assign accept      = req_valid && req_ready;
   assign idx_dec     = idx_ff - CW'(1);
   assign rd_pri      = mem_rd_data[DW-1:VALUE_BITS];
   assign rd_val      = mem_rd_data[VALUE_BITS-1:0];
   // compare unit: stored entry keeps its place if priority is equal or higher
   assign stays_ahead = $signed(rd_pri) >= $signed(new_pri_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      status_ff   <= status_in;
      new_pri_ff  <= new_pri_in;
      new_val_ff  <= new_val_in;
      head_pri_ff <= head_pri_in;
      head_val_ff <= head_val_in;
      removed_ff  <= removed_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      new_pri_in  = new_pri_ff;
      new_val_in  = new_val_ff;
      head_pri_in = head_pri_ff;
      head_val_in = head_val_ff;
      removed_in  = removed_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = {new_pri_ff, new_val_ff};
      mem_rd_addr = idx_ff[AW-1:0];
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               op_in      = req_mode;
               new_pri_in = req_priority;
               new_val_in = req_value;
               status_in  = STATUS_DONE;
               removed_in = '0;
               if (req_mode == MODE_INSERT) begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else if (count_ff == '0) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = '0;
                     mem_wr_data = {req_priority, req_value};
                     head_pri_in = req_priority;
                     head_val_in = req_value;
                     count_in    = CW'(1);
                     state_in    = ST_DONE;
                  end else begin
                     idx_in   = count_ff;
                     state_in = ST_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     removed_in = head_val_ff;
                     count_in   = count_ff - CW'(1);
                     idx_in     = CW'(1);
                     state_in   = (count_ff == CW'(1)) ? ST_DONE : ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            mem_rd_addr = (op_ff == MODE_INSERT) ? idx_dec[AW-1:0] : idx_ff[AW-1:0];
            state_in    = ST_MOVE;
         end
         ST_MOVE: begin
            mem_wr_en = 1'b1;
            if (op_ff == MODE_INSERT) begin
               if (stays_ahead) begin
                  mem_wr_addr = idx_ff[AW-1:0];
                  count_in    = count_ff + CW'(1);
                  state_in    = ST_DONE;
               end else begin
                  mem_wr_addr = idx_ff[AW-1:0];
                  mem_wr_data = mem_rd_data;
                  idx_in      = idx_dec;
                  state_in    = (idx_dec == '0) ? ST_PLACE : ST_READ;
               end
            end else begin
               mem_wr_addr = idx_dec[AW-1:0];
               mem_wr_data = mem_rd_data;
               if (idx_ff == CW'(1)) begin
                  head_pri_in = rd_pri;
                  head_val_in = rd_val;
               end
               if (idx_ff == count_ff) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            head_pri_in = new_pri_ff;
            head_val_in = new_val_ff;
            count_in    = count_ff + CW'(1);
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_removed_value  = removed_ff;
   assign res_head_priority  = (count_ff == '0) ? '0 : head_pri_ff;
   assign res_head_value     = (count_ff == '0) ? '0 : head_val_ff;
   assign res_flags.is_empty = (count_ff == '0);
   assign res_flags.is_full  = (count_ff == CW'(DEPTH));
   assign res_flags.status   = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_REMOVE && count_ff != '0)
         |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not drop count");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> CW'(mem_wr_addr) <= count_ff)
      else $error("write beyond occupied range");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_flags.status == STATUS_FULL) |-> res_flags.is_full)
      else $error("rejected insert without full flag");

endmodule

`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
// Insert: each entry of lower priority is read and moved back one place, then the
//   new entry is written in the gap; an empty or full queue skips the moves.
// Remove: the remaining entries are each read and moved forward one place.
// Throughput: one item at a time, next transfer accepted as the result can leave;
//   each moved entry is read from and written back to the entry memory.
// Reset: entry count cleared, queue empty; entry memory is not cleared.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   localparam int REQ_BITS     = ((PRIORITY_BITS + VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_RAW      = 2 * VALUE_BITS + PRIORITY_BITS + 4,
   localparam int RSP_BITS     = ((RSP_RAW + 7) / 8) * 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // priority_req, value
   input  wire logic [REQ_BITS-1:0] req_tdata,
   // mode
   input  wire logic [0:0]          req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // removed_value, head_priority, head_value, is_empty, is_full, status
   output logic [RSP_BITS-1:0]      rsp_tdata
);

   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW     = PRIORITY_BITS + VALUE_BITS;
   localparam int OFS_HP = VALUE_BITS;
   localparam int OFS_HV = VALUE_BITS + PRIORITY_BITS;
   localparam int OFS_FL = 2 * VALUE_BITS + PRIORITY_BITS;

   logic                     res_valid, res_ready;
   logic [VALUE_BITS-1:0]    res_removed_value, res_head_value;
   logic [PRIORITY_BITS-1:0] res_head_priority;
   res_flags_type            res_flags;
   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr, mem_rd_addr;
   logic [DW-1:0]            mem_wr_data, mem_rd_data;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]      rsp_data_ff, rsp_data_in;

   spq_ctrl #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .VALUE_BITS    (VALUE_BITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_mode          (mode_type'(req_tuser[0])),
      .req_priority      (req_tdata[PRIORITY_BITS-1:0]),
      .req_value         (req_tdata[DW-1:PRIORITY_BITS]),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res_removed_value (res_removed_value),
      .res_head_priority (res_head_priority),
      .res_head_value    (res_head_value),
      .res_flags         (res_flags),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   spq_mem #(
      .DEPTH     (DEPTH),
      .DATA_BITS (DW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   // output register parts the result from the sequencer
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[VALUE_BITS-1:0]                = res_removed_value;
         rsp_data_in[OFS_HP +: PRIORITY_BITS]       = res_head_priority;
         rsp_data_in[OFS_HV +: VALUE_BITS]          = res_head_value;
         rsp_data_in[OFS_FL]                        = res_flags.is_empty;
         rsp_data_in[OFS_FL + 1]                    = res_flags.is_full;
         rsp_data_in[OFS_FL + 2 +: 2]               = res_flags.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* tb/sv/priority_queue_checker.sv */
`timescale 1ns / 100ps

module priority_queue_checker
   import spq_pkg::*;
#(
   parameter int REQ_BITS = 48,
   parameter int RSP_BITS = 88
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tready,
   // priority_req, value
   input  wire logic [REQ_BITS-1:0] req_tdata,
   // mode
   input  wire logic [0:0]          req_tuser,
   input  wire logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   // removed_value, head_priority, head_value, is_empty, is_full, status
   input  wire logic [RSP_BITS-1:0] rsp_tdata,
   output int                       fail_count,
   output int                       pending
);

   localparam int QDEPTH = DEPTH_DEF;
   localparam int PW     = PRIORITY_BITS_DEF;
   localparam int VW     = VALUE_BITS_DEF;

   // first declared field lands in the top bits, so this matches the tdata layout
   typedef struct packed {
      status_type            status;
      logic                  is_full;
      logic                  is_empty;
      logic [VW-1:0]         head_value;
      logic signed [PW-1:0]  head_priority;
      logic [VW-1:0]         removed_value;
   } queue_result_t;

   logic signed [PW-1:0] entry_prio [QDEPTH];
   logic [VW-1:0]        entry_val  [QDEPTH];
   int                   entry_count;
   queue_result_t        predicted_rsp[$];
   int                   fail_total;

   initial begin
      fail_count  = 0;
      pending     = 0;
      fail_total  = 0;
      entry_count = 0;
   end

   function automatic queue_result_t apply_queue_op(input mode_type m,
                                                    input logic signed [PW-1:0] p,
                                                    input logic [VW-1:0] v);
      queue_result_t r;
      int pos;
      r = '0;
      r.status = STATUS_DONE;
      if (m == MODE_INSERT) begin
         if (entry_count >= QDEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < entry_count && entry_prio[pos] >= p) pos++;
            for (int i = entry_count; i > pos; i--) begin
               entry_prio[i] = entry_prio[i-1];
               entry_val[i]  = entry_val[i-1];
            end
            entry_prio[pos] = p;
            entry_val[pos]  = v;
            entry_count++;
         end
      end else begin
         if (entry_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.removed_value = entry_val[0];
            for (int i = 1; i < entry_count; i++) begin
               entry_prio[i-1] = entry_prio[i];
               entry_val[i-1]  = entry_val[i];
            end
            entry_count--;
         end
      end
      if (entry_count > 0) begin
         r.head_priority = entry_prio[0];
         r.head_value    = entry_val[0];
      end
      r.is_empty = (entry_count == 0);
      r.is_full  = (entry_count >= QDEPTH);
      return r;
   endfunction

   function automatic int field_diff(input string name, input longint want,
                                     input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : monitor
      queue_result_t got;
      queue_result_t want;
      int errs;
      if (reset) begin
         entry_count = 0;
         predicted_rsp.delete();
      end else begin
         errs = 0;
         if (rsp_tvalid && rsp_tready) begin
            got = queue_result_t'(rsp_tdata[$bits(queue_result_t)-1:0]);
            if (predicted_rsp.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               errs++;
            end else begin
               want = predicted_rsp.pop_front();
               errs += field_diff("removed_value", $signed(want.removed_value),
                                  $signed(got.removed_value));
               errs += field_diff("head_priority", want.head_priority,
                                  got.head_priority);
               errs += field_diff("head_value", $signed(want.head_value),
                                  $signed(got.head_value));
               errs += field_diff("is_empty", want.is_empty, got.is_empty);
               errs += field_diff("is_full", want.is_full, got.is_full);
               errs += field_diff("status", want.status, got.status);
            end
         end
         if (req_tvalid && req_tready)
            predicted_rsp.push_back(apply_queue_op(mode_type'(req_tuser[0]),
                                                   req_tdata[PW-1:0],
                                                   req_tdata[PW+VW-1:PW]));
         fail_total += errs;
      end
      fail_count <= fail_total;
      pending    <= predicted_rsp.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
   import spq_pkg::*;

   localparam int PW           = PRIORITY_BITS_DEF;
   localparam int VW           = VALUE_BITS_DEF;
   localparam int REQ_BITS     = ((PW + VW + 7) / 8) * 8;
   localparam int RSP_BITS     = ((2 * VW + PW + 4 + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1630;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 60;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata  = '0;
   logic [0:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   int                  fail_count;
   int                  pending;
   bit                  no_idle     = 1'b0;
   bit                  hold_off_go = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   sorted_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   priority_queue_checker #(
      .REQ_BITS (REQ_BITS),
      .RSP_BITS (RSP_BITS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // result side: random back-pressure, one long hold-off on request
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_go) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_go = 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 17);
            @(posedge clock);
         end
      end
   end

   function automatic logic [PW-1:0] pick_priority();
      case ($urandom_range(9))
         0:       return {1'b1, {(PW-1){1'b0}}};
         1:       return {1'b0, {(PW-1){1'b1}}};
         2, 3:    return PW'($urandom);
         default: return PW'($urandom_range(8)) - PW'(4);
      endcase
   endfunction

   function automatic logic [VW-1:0] pick_value();
      case ($urandom_range(7))
         0:       return {1'b1, {(VW-1){1'b0}}};
         1:       return {1'b0, {(VW-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return VW'($urandom);
      endcase
   endfunction

   task automatic send_op(input mode_type m, input logic [PW-1:0] p,
                          input logic [VW-1:0] v);
      while (!no_idle && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {v, p};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : stimulus
      int seg;
      int len;
      int insert_pct;
      int sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty remove, extreme and tied priorities, drain past empty
      send_op(MODE_REMOVE, 16'h0000, 32'h0000_0000);
      send_op(MODE_INSERT, 16'h0000, 32'h0000_0000);
      send_op(MODE_INSERT, 16'h7fff, 32'h7fff_ffff);
      send_op(MODE_INSERT, 16'h8000, 32'h8000_0000);
      send_op(MODE_INSERT, 16'h7fff, 32'h0000_0001);
      send_op(MODE_INSERT, 16'hffff, 32'hffff_ffff);
      send_op(MODE_INSERT, 16'h0000, 32'h1234_5678);
      send_op(MODE_INSERT, 16'h8000, 32'h5a5a_5a5a);
      send_op(MODE_INSERT, 16'h0001, 32'ha5a5_a5a5);
      repeat (9) send_op(MODE_REMOVE, 16'hffff, 32'hffff_ffff);
      send_op(MODE_INSERT, 16'h8000, 32'hdead_beef);
      send_op(MODE_REMOVE, 16'h5555, 32'h5555_5555);
      send_op(MODE_REMOVE, 16'haaaa, 32'haaaa_aaaa);
      wait_drained();

      seg  = 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
         endcase
         len = $urandom_range(20, 60);
         no_idle = (seg == 3);
         if (seg == 6) begin
            hold_off_go = 1'b1;
            insert_pct  = 100;
            len         = 40;
         end
         if (seg == 12) wait_drained();
         repeat (len) begin
            if ($urandom_range(99) < insert_pct)
               send_op(MODE_INSERT, pick_priority(), pick_value());
            else
               send_op(MODE_REMOVE, pick_priority(), pick_value());
            sent++;
         end
         seg++;
      end
      no_idle = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
